>>> hw/rtl/assert_macros.svh
// Assertion shorthands shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define SBDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define SBDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/sbdt_pkg.sv
package sbdt_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int NUM_DIGITS = ((WORD_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int STEP_W     = $clog2(WORD_WIDTH + 1);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic neg;
  } emit_ctl_t;

  typedef struct packed {
    logic active;
    logic fin;
  } emit_stat_t;

endpackage

>>> hw/rtl/sbdt_dabble.sv
`include "assert_macros.svh"

module sbdt_dabble
  import sbdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [WORD_WIDTH-1:0] mag,
  output logic                  done,
  output logic [BCD_W-1:0]      bcd
);

  logic [WORD_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BCD_W-1:0]      adj;
  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (load) begin
      mag_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = STEP_W'(WORD_WIDTH);
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {adj[BCD_W-2:0], mag_r[WORD_WIDTH-1]};
      mag_nxt = {mag_r[WORD_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

  `SBDT_ASSERT_SAME(a_done_idle, clk, rst_n, done_r, !run_r)
  `SBDT_ASSERT_SAME(a_load_idle, clk, rst_n, load, !run_r)

endmodule

>>> hw/rtl/sbdt_emit.sv
`include "assert_macros.svh"

module sbdt_emit
  import sbdt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  emit_ctl_t        ctl,
  input  logic [BCD_W-1:0] bcd,
  output emit_stat_t       stat,
  output logic             strobe,
  output logic [7:0]       char_code,
  output logic             is_last
);

  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [DIG_CNT_W-1:0] left_r, left_nxt;
  logic                 act_r, act_nxt;
  logic                 sign_r, sign_nxt;
  logic                 started_r, started_nxt;
  logic                 strobe_r, strobe_nxt;
  logic [7:0]           char_r, char_nxt;
  logic                 last_r, last_nxt;
  logic [3:0]           digit;
  logic                 final_digit;

  assign digit       = bcd_r[BCD_W-1 -: 4];
  assign final_digit = (left_r == DIG_CNT_W'(1));

  always_comb begin
    bcd_nxt     = bcd_r;
    left_nxt    = left_r;
    act_nxt     = act_r;
    sign_nxt    = sign_r;
    started_nxt = started_r;
    strobe_nxt  = 1'b0;
    char_nxt    = char_r;
    last_nxt    = 1'b0;
    if (ctl.load) begin
      bcd_nxt     = bcd;
      left_nxt    = DIG_CNT_W'(NUM_DIGITS);
      act_nxt     = 1'b1;
      sign_nxt    = ctl.neg;
      started_nxt = 1'b0;
    end else if (act_r) begin
      if (sign_r) begin
        strobe_nxt = 1'b1;
        char_nxt   = CHAR_MINUS;
        sign_nxt   = 1'b0;
      end else begin
        strobe_nxt  = started_r || (digit != 4'd0) || final_digit;
        char_nxt    = CHAR_ZERO + {4'd0, digit};
        last_nxt    = final_digit;
        started_nxt = started_r || (digit != 4'd0);
        bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
        left_nxt    = left_r - DIG_CNT_W'(1);
        if (final_digit) begin
          act_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    bcd_r     <= bcd_nxt;
    left_r    <= left_nxt;
    sign_r    <= sign_nxt;
    started_r <= started_nxt;
    char_r    <= char_nxt;
    if (!rst_n) begin
      act_r    <= 1'b0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      act_r    <= act_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
    end
  end

  assign stat.active = act_r;
  assign stat.fin    = act_r && !sign_r && final_digit;
  assign strobe      = strobe_r;
  assign char_code   = char_r;
  assign is_last     = last_r;

  `SBDT_ASSERT_SAME(a_last_strobed, clk, rst_n, last_r, strobe_r)
  `SBDT_ASSERT_SAME(a_minus_not_last, clk, rst_n, strobe_r && (char_r == CHAR_MINUS), !last_r)

endmodule

>>> hw/rtl/signed_binary_to_decimal_text.sv
// Emission starts once the bit-serial shift-add-3 loop has converted the word; a negative word
// strobes its minus sign first, and leading zero digits are shifted out without a strobe.
// A new word is taken only while busy is low; busy stays high until the last character is emitted,
// so words do not overlap. The emit shifter moves out one digit per cycle.
// Digit characters follow on consecutive cycles from the first strobed digit on.
// Reset (rst_n low, synchronous) drops any word in flight and clears busy and out_strobe.
`include "assert_macros.svh"

module signed_binary_to_decimal_text
  import sbdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [WORD_WIDTH-1:0] in_bit_pattern,
  output logic                  out_strobe,
  output logic [7:0]            out_char_code,
  output logic                  out_is_last
);

  state_t                state_r, state_nxt;
  logic                  neg_r, neg_nxt;
  logic                  accept;
  logic                  in_neg;
  logic [WORD_WIDTH-1:0] in_mag;
  logic                  conv_done;
  logic [BCD_W-1:0]      conv_bcd;
  emit_ctl_t             ectl;
  emit_stat_t            estat;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign in_neg = in_bit_pattern[WORD_WIDTH-1];
  assign in_mag = in_neg ? (~in_bit_pattern + WORD_WIDTH'(1)) : in_bit_pattern;

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CONV;
          neg_nxt   = in_neg;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (estat.fin) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign ectl.load = conv_done;
  assign ectl.neg  = neg_r;

  sbdt_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .mag   (in_mag),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  sbdt_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ectl),
    .bcd       (conv_bcd),
    .stat      (estat),
    .strobe    (out_strobe),
    .char_code (out_char_code),
    .is_last   (out_is_last)
  );

  `SBDT_ASSERT_NEXT(a_accept_conv, clk, rst_n, accept, state_r == ST_CONV)
  `SBDT_ASSERT_SAME(a_emit_in_state, clk, rst_n, estat.active, state_r == ST_EMIT)

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sbdt_pkg::*;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  localparam int STALL_LIMIT = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [WORD_WIDTH-1:0] in_bit_pattern;
  logic                  out_strobe;
  logic [7:0]            out_char_code;
  logic                  out_is_last;

  text_char_t text_q[$];
  int         error_count;
  int         sender_idle_pct;
  int         quiet_cycles;

  signed_binary_to_decimal_text u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_bit_pattern(in_bit_pattern),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  function automatic void predict_text(input logic [WORD_WIDTH-1:0] word);
    logic [WORD_WIDTH-1:0] mag;
    logic [7:0]            digits[$];
    logic                  neg;
    text_char_t            c;
    neg = word[WORD_WIDTH-1];
    mag = neg ? (~word + 1'b1) : word;
    do begin
      digits.push_front(CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    foreach (digits[i]) begin
      c.code = digits[i];
      c.last = (i == digits.size() - 1);
      text_q.push_back(c);
    end
  endfunction

  function automatic logic [WORD_WIDTH-1:0] pick_word();
    logic [WORD_WIDTH-1:0] w;
    longint unsigned       pw;
    int unsigned           p;
    case ($urandom_range(5))
      0, 1: w = WORD_WIDTH'({$urandom, $urandom});
      2: w = WORD_WIDTH'($urandom_range(999));
      3: begin
        p = $urandom_range(WORD_WIDTH - 1);
        w = WORD_WIDTH'(1) << p;
        if ($urandom_range(1)) w = w - 1'b1;
      end
      default: begin
        pw = 1;
        repeat ($urandom_range(9)) pw = pw * 10;
        w = WORD_WIDTH'(pw) + WORD_WIDTH'($urandom_range(2)) - 1'b1;
      end
    endcase
    if ($urandom_range(1)) w = ~w + 1'b1;
    return w;
  endfunction

  task automatic send_word(input logic [WORD_WIDTH-1:0] w);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_bit_pattern <= w;
    do @(posedge clk); while (busy);
    predict_text(w);
  endtask

  task automatic wait_text_drained();
    start <= 1'b0;
    do @(posedge clk); while (text_q.size() != 0);
  endtask

  task automatic test_extremes();
    logic [WORD_WIDTH-1:0] words[$];
    sender_idle_pct = 0;
    words = '{'0, WORD_WIDTH'(1), '1, WORD_WIDTH'(9), WORD_WIDTH'(10),
              WORD_WIDTH'(-10), WORD_WIDTH'(99), WORD_WIDTH'(100),
              {1'b0, {(WORD_WIDTH-1){1'b1}}}, {1'b1, {(WORD_WIDTH-1){1'b0}}},
              {1'b1, {(WORD_WIDTH-2){1'b0}}, 1'b1},
              WORD_WIDTH'(999999999), WORD_WIDTH'(1000000000),
              WORD_WIDTH'(-999999999), WORD_WIDTH'(-1000000000),
              {(WORD_WIDTH/2){2'b10}}, {(WORD_WIDTH/2){2'b01}}};
    foreach (words[i]) send_word(words[i]);
  endtask

  task automatic test_drain_pause();
    sender_idle_pct = 0;
    repeat (2) begin
      repeat (3) send_word(pick_word());
      wait_text_drained();
    end
  endtask

  task automatic test_random_words(input int idle_pct, input int count);
    sender_idle_pct = idle_pct;
    repeat (count) send_word(pick_word());
  endtask

  always @(posedge clk) begin
    text_char_t exp_c;
    if (rst_n && out_strobe) begin
      if (text_q.size() == 0) begin
        $display("%0t: unexpected char expected none actual code %0d last %0b",
                 $time, out_char_code, out_is_last);
        error_count++;
      end else begin
        exp_c = text_q.pop_front();
        if (out_char_code !== exp_c.code) begin
          $display("%0t: char_code expected %0d actual %0d", $time, exp_c.code,
                   out_char_code);
          error_count++;
        end
        if (out_is_last !== exp_c.last) begin
          $display("%0t: is_last expected %0b actual %0b", $time, exp_c.last,
                   out_is_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no activity for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    error_count     = 0;
    quiet_cycles    = 0;
    sender_idle_pct = 0;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_bit_pattern <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_drain_pause();
    test_random_words(24, 65);
    test_random_words(87, 60);
    test_random_words(0, 60);
    wait_text_drained();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
